### hdl/upwd_pkg.sv
// Package for the ultrasonic presence window detector.
// Holds widths, register indexes, reset values and shared types; no dependencies.
`timescale 1ns / 1ps

package upwd_pkg;

    localparam int TIME_BITS  = 32;
    localparam int TMS_W      = 32;
    localparam int ECHO_W     = 20;
    localparam int IVL_W      = 16;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HITS_NEEDED = 3'd4;

    localparam logic [ECHO_W-1:0] NEAR_LIMIT_RST  = 20'd1765;
    localparam logic [ECHO_W-1:0] FAR_LIMIT_RST   = 20'd4117;
    localparam logic [IVL_W-1:0]  INTERVAL_RST    = 16'd20;
    localparam logic [CNT_W-1:0]  WINDOW_LEN_RST  = 8'd25;
    localparam logic [CNT_W-1:0]  HITS_NEEDED_RST = 8'd10;

    typedef logic [TIME_BITS-1:0] time_val_t;

    typedef struct packed {
        logic [ECHO_W-1:0] near_limit_us;
        logic [ECHO_W-1:0] far_limit_us;
        logic [IVL_W-1:0]  interval_ms;
        logic [CNT_W-1:0]  window_len;
        logic [CNT_W-1:0]  hits_needed;
    } cfg_t;

    typedef struct packed {
        logic sampled;
        logic detected;
        logic notify_on;
    } result_t;

endpackage

### hdl/ultrasonic_presence_window_detector_unit.sv
// Top level of the ultrasonic presence window detector: input and result stages.
// Depends on upwd_pkg, upwd_cfg and upwd_eval.
//
// Channel | Direction | Transaction
// s_      | in        | one item: time_ms, echo_us
// m_      | out       | one result per item: sampled, detected, notify_on
// cfg_    | in        | one register write: index, data
//
// One item per cycle sustained while the result side takes every result; an accepted
// item passes through the input register and then the result register before its
// result is valid.
// Evaluation and state update happen as an item moves into the result register.
// A stalled result holds the input stage; s_tready falls only when both are full.
// Reset is synchronous, active low; it clears the valid flags and window state and loads the config reset values.
`timescale 1ns / 1ps

module ultrasonic_presence_window_detector_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [upwd_pkg::S_DATA_W-1:0]   s_tdata,   // time_ms[31:0], echo_us[51:32], zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [upwd_pkg::M_DATA_W-1:0]   m_tdata,   // sampled[0], detected[1], notify_on[2], zero
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [upwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [upwd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import upwd_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [TMS_W-1:0]  time_reg;
    logic [ECHO_W-1:0] echo_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;

    logic s_accept;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 3){1'b0}},
                       out_reg.notify_on, out_reg.detected, out_reg.sampled};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            time_reg <= s_tdata[TMS_W-1:0];
            echo_reg <= s_tdata[TMS_W+ECHO_W-1:TMS_W];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    upwd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    upwd_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .time_ms (time_reg),
        .echo_us (echo_reg),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

### hdl/upwd_cfg.sv
// Configuration register file of the presence window detector.
// Depends on upwd_pkg.
`timescale 1ns / 1ps

module upwd_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [upwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [upwd_pkg::CFG_DATA_W-1:0] cfg_data,
    output upwd_pkg::cfg_t                  cfg
);
    import upwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_NEAR_LIMIT:  cfg_next.near_limit_us = cfg_data[ECHO_W-1:0];
                REG_FAR_LIMIT:   cfg_next.far_limit_us  = cfg_data[ECHO_W-1:0];
                REG_INTERVAL:    cfg_next.interval_ms   = cfg_data[IVL_W-1:0];
                REG_WINDOW_LEN:  cfg_next.window_len    = cfg_data[CNT_W-1:0];
                REG_HITS_NEEDED: cfg_next.hits_needed   = cfg_data[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit_us <= NEAR_LIMIT_RST;
            cfg_reg.far_limit_us  <= FAR_LIMIT_RST;
            cfg_reg.interval_ms   <= INTERVAL_RST;
            cfg_reg.window_len    <= WINDOW_LEN_RST;
            cfg_reg.hits_needed   <= HITS_NEEDED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/upwd_eval.sv
// Sample timing, hit test and window state of the presence window detector.
// Depends on upwd_pkg.
`timescale 1ns / 1ps

module upwd_eval (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_en,
    input  logic [upwd_pkg::TMS_W-1:0]  time_ms,
    input  logic [upwd_pkg::ECHO_W-1:0] echo_us,
    input  upwd_pkg::cfg_t              cfg,
    output upwd_pkg::result_t           result
);
    import upwd_pkg::*;

    time_val_t        start_reg;
    time_val_t        start_next;
    logic [CNT_W-1:0] wcount_reg;
    logic [CNT_W-1:0] wcount_next;
    logic [CNT_W-1:0] hcount_reg;
    logic [CNT_W-1:0] hcount_next;
    logic             notify_reg;
    logic             notify_next;

    time_val_t now;
    time_val_t st_load;
    time_val_t st_clip;
    time_val_t elapsed;
    logic      due;
    logic      hit;
    logic      detect;

    always_comb begin
        now      = TIME_BITS'(time_ms);
        st_load  = (start_reg == '0) ? now : start_reg;
        st_clip  = (st_load > now) ? now : st_load;
        elapsed  = now - st_clip;
        due      = elapsed >= TIME_BITS'(cfg.interval_ms);
        hit      = (echo_us >= cfg.near_limit_us) && (echo_us <= cfg.far_limit_us);

        start_next  = st_clip;
        wcount_next = wcount_reg;
        hcount_next = hcount_reg;
        notify_next = notify_reg;
        detect      = 1'b0;

        if (due) begin
            start_next = now;
            if (wcount_reg != '0) begin
                wcount_next = wcount_reg + CNT_W'(1);
            end
            if (hit) begin
                if (wcount_next == '0) begin
                    wcount_next = CNT_W'(1);
                    hcount_next = CNT_W'(1);
                    notify_next = 1'b1;
                end else if (hcount_reg != '1) begin
                    hcount_next = hcount_reg + CNT_W'(1);
                end
            end else if (wcount_next == '0) begin
                notify_next = 1'b0;
            end
            if (wcount_next != '0 && wcount_next == cfg.window_len) begin
                wcount_next = '0;
                detect      = hcount_next >= cfg.hits_needed;
            end
        end

        result.sampled   = due;
        result.detected  = detect;
        result.notify_on = notify_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            wcount_reg <= '0;
            hcount_reg <= '0;
            notify_reg <= 1'b0;
        end else if (item_en) begin
            start_reg  <= start_next;
            wcount_reg <= wcount_next;
            hcount_reg <= hcount_next;
            notify_reg <= notify_next;
        end
    end

endmodule

### hdl/upwd_checker.sv
// Port-level checks for the presence window detector, bound to the top level.
// Depends on upwd_pkg and ultrasonic_presence_window_detector_unit.
`timescale 1ns / 1ps

module upwd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [upwd_pkg::M_DATA_W-1:0]   m_tdata
);
    import upwd_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_detect_sampled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("detection without a sample");

    a_detect_notify: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
        else $error("detection with notifier off");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ultrasonic_presence_window_detector_unit upwd_checker u_upwd_checker (.*);

### tb/tb_ultrasonic_presence_window_detector_unit.sv
// Self-checking testbench for ultrasonic_presence_window_detector_unit.
// It runs a directed table and then random phases, and predicts every verdict
// with its own model of the detector. It depends on upwd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_ultrasonic_presence_window_detector_unit;
    import upwd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_PHASES   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    localparam result_t R_QUIET      = '{1'b0, 1'b0, 1'b0};
    localparam result_t R_QUIET_ON   = '{1'b0, 1'b0, 1'b1};
    localparam result_t R_SAMPLE_ON  = '{1'b1, 1'b0, 1'b1};
    localparam result_t R_SAMPLE_OFF = '{1'b1, 1'b0, 1'b0};
    localparam result_t R_DETECT     = '{1'b1, 1'b1, 1'b1};

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        time_val_t             t_ms;
        logic [ECHO_W-1:0]     echo_us;
        logic                  typed;
        result_t               want;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    cfg_t              shadow_cfg;
    time_val_t         pres_start;
    logic [CNT_W-1:0]  pres_win;
    logic [CNT_W-1:0]  pres_hits;
    logic              pres_notify;
    result_t           pending_verdicts[$];
    dir_row_t          dir_rows[$];

    int errors         = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int samples_seen   = 0;
    int detects_seen   = 0;
    int hold_requests  = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int cycle_count    = 0;

    ultrasonic_presence_window_detector_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, pending_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (result %0d, t=%0t)",
                 what, got, want, results_seen, $realtime);
        errors++;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_NEAR_LIMIT:  shadow_cfg.near_limit_us = val[ECHO_W-1:0];
            REG_FAR_LIMIT:   shadow_cfg.far_limit_us  = val[ECHO_W-1:0];
            REG_INTERVAL:    shadow_cfg.interval_ms   = val[IVL_W-1:0];
            REG_WINDOW_LEN:  shadow_cfg.window_len    = val[CNT_W-1:0];
            REG_HITS_NEEDED: shadow_cfg.hits_needed   = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t predict_presence(input time_val_t now,
                                                 input logic [ECHO_W-1:0] echo);
        result_t r;
        logic    hit;
        r = R_QUIET;
        if (pres_start == '0)
            pres_start = now;
        if (pres_start > now)
            pres_start = now;
        if (time_val_t'(now - pres_start) >= time_val_t'(shadow_cfg.interval_ms)) begin
            hit = (echo >= shadow_cfg.near_limit_us) && (echo <= shadow_cfg.far_limit_us);
            r.sampled  = 1'b1;
            pres_start = now;
            if (pres_win != '0)
                pres_win = pres_win + 1'b1;
            if (hit) begin
                if (pres_win == '0) begin
                    pres_win    = 1;
                    pres_hits   = 1;
                    pres_notify = 1'b1;
                end else if (pres_hits != '1) begin
                    pres_hits = pres_hits + 1'b1;
                end
            end else if (pres_win == '0) begin
                pres_notify = 1'b0;
            end
            if (pres_win != '0 && pres_win == shadow_cfg.window_len) begin
                pres_win   = '0;
                r.detected = (pres_hits >= shadow_cfg.hits_needed);
            end
        end
        r.notify_on = pres_notify;
        return r;
    endfunction

    task automatic offer_echo(input time_val_t t_ms, input logic [ECHO_W-1:0] echo_us,
                              input logic typed, input result_t want);
        result_t p;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - ECHO_W - TMS_W){1'b0}}, echo_us, t_ms};
        do @(posedge aclk); while (!s_tready);
        p = predict_presence(t_ms, echo_us);
        if (typed && p !== want)
            report_mismatch("table row against predictor", p, want);
        pending_verdicts.push_back(typed ? want : p);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drop valid, drain every outstanding verdict, then let the pipeline empty
    task automatic settle;
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : verdict_sink
        int      hold_left;
        int      holds_served;
        result_t exp_r;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    exp_r = pending_verdicts.pop_front();
                    if (m_tdata[0] !== exp_r.sampled)
                        report_mismatch("sampled", m_tdata[0], exp_r.sampled);
                    if (m_tdata[1] !== exp_r.detected)
                        report_mismatch("detected", m_tdata[1], exp_r.detected);
                    if (m_tdata[2] !== exp_r.notify_on)
                        report_mismatch("notify_on", m_tdata[2], exp_r.notify_on);
                    samples_seen += exp_r.sampled;
                    detects_seen += exp_r.detected;
                end
                results_seen++;
            end
            // hold off the result side while the sender keeps offering
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        cfg_t              ph_cfg;
        time_val_t         clock_ms;
        time_val_t         t_ms;
        logic [ECHO_W-1:0] echo;
        int                roll;
        int                n_items;

        shadow_cfg  = '{NEAR_LIMIT_RST, FAR_LIMIT_RST, INTERVAL_RST,
                        WINDOW_LEN_RST, HITS_NEEDED_RST};
        pres_start  = '0;
        pres_win    = '0;
        pres_hits   = '0;
        pres_notify = 1'b0;

        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd0, 20'd0, 1'b1, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd100, 20'd2000, 1'b1, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd120, 20'd1765, 1'b1,
                             R_SAMPLE_ON});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd130, 20'd4117, 1'b1,
                             R_QUIET_ON});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd140, 20'd4118, 1'b1,
                             R_SAMPLE_ON});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd50, 20'd0, 1'b1, R_QUIET_ON});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd70, 20'd1764, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1,
                             R_SAMPLE_ON});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd5, 20'd0, 1'b1, R_QUIET_ON});
        dir_rows.push_back('{1'b1, REG_INTERVAL, 20'd0, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_WINDOW_LEN, 20'd6, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_HITS_NEEDED, 20'd2, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd5, 20'd2000, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd5, 20'd3000, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd5, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_HITS_NEEDED, 20'd0, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_WINDOW_LEN, 20'd1, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd6, 20'd2000, 1'b1, R_DETECT});
        dir_rows.push_back('{1'b1, REG_NEAR_LIMIT, 20'hFFFFF, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_FAR_LIMIT, 20'd0, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd7, 20'd2000, 1'b1,
                             R_SAMPLE_OFF});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd8, 20'hFFFFF, 1'b1,
                             R_SAMPLE_OFF});
        dir_rows.push_back('{1'b1, REG_NEAR_LIMIT, 20'd0, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_FAR_LIMIT, 20'hFFFFF, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_WINDOW_LEN, 20'd0, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd9, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'd10, 20'hFFFFF, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b1, REG_INTERVAL, 20'hFFFF, 32'd0, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'h1_0000, 20'd0, 1'b0, R_QUIET});
        dir_rows.push_back('{1'b0, REG_NEAR_LIMIT, 20'd0, 32'h1_0009, 20'd0, 1'b0, R_QUIET});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 34;
        rx_idle_pct = 53;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                offer_echo(dir_rows[i].t_ms, dir_rows[i].echo_us, dir_rows[i].typed,
                           dir_rows[i].want);
            end
        end

        clock_ms = 32'h200;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin ph_cfg = '{20'd1765, 20'd4117, 16'd20, 8'd25, 8'd10}; n_items = 100; end
                1: begin ph_cfg = '{20'd1000, 20'd3000, 16'd0, 8'd4, 8'd2}; n_items = 100; end
                2: begin ph_cfg = '{20'd0, 20'hFFFFF, 16'd5, 8'd255, 8'd255}; n_items = 80; end
                3: begin ph_cfg = '{20'd0, 20'hFFFFF, 16'd0, 8'd0, 8'd0}; n_items = 300; end
                4: begin ph_cfg = '{20'hFFFFF, 20'd0, 16'd3, 8'd7, 8'd3}; n_items = 100; end
                default: begin
                    ph_cfg.near_limit_us = $urandom_range(0, 3000);
                    ph_cfg.far_limit_us  = ph_cfg.near_limit_us + $urandom_range(0, 3000);
                    ph_cfg.interval_ms   = $urandom_range(0, 40);
                    ph_cfg.window_len    = $urandom_range(1, 10);
                    ph_cfg.hits_needed   = $urandom_range(0, ph_cfg.window_len);
                    n_items = 100;
                end
            endcase
            write_reg(REG_NEAR_LIMIT,  CFG_DATA_W'(ph_cfg.near_limit_us));
            write_reg(REG_FAR_LIMIT,   CFG_DATA_W'(ph_cfg.far_limit_us));
            write_reg(REG_INTERVAL,    CFG_DATA_W'(ph_cfg.interval_ms));
            write_reg(REG_WINDOW_LEN,  CFG_DATA_W'(ph_cfg.window_len));
            write_reg(REG_HITS_NEEDED, CFG_DATA_W'(ph_cfg.hits_needed));
            if (ph == 4) begin
                // upper bits beyond a register's width must be dropped
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
                write_reg(REG_INTERVAL, 20'hF0003);
                write_reg(REG_WINDOW_LEN, 20'hABC07);
            end
            tx_idle_pct = (ph % 3 == 0) ? 34 : (ph % 3 == 1) ? 53 : 0;
            rx_idle_pct = (ph % 3 == 0) ? 53 : (ph % 3 == 1) ? 34 : 0;

            for (int k = 0; k < n_items; k++) begin
                if (ph == 1 && k == 30)
                    hold_requests++;
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    clock_ms = clock_ms + $urandom_range(0, 2 * shadow_cfg.interval_ms + 2);
                    t_ms     = clock_ms;
                end else if (roll < 90) begin
                    t_ms = $urandom;
                end else if (roll < 95) begin
                    t_ms = '0;
                end else begin
                    clock_ms = clock_ms - $urandom_range(0, 100);
                    t_ms     = clock_ms;
                end
                roll = $urandom_range(0, 99);
                if (roll < 50 && shadow_cfg.near_limit_us <= shadow_cfg.far_limit_us)
                    echo = $urandom_range(shadow_cfg.near_limit_us, shadow_cfg.far_limit_us);
                else if (roll < 58)
                    echo = shadow_cfg.near_limit_us + ECHO_W'($urandom_range(0, 2)) - 1'b1;
                else if (roll < 66)
                    echo = shadow_cfg.far_limit_us + ECHO_W'($urandom_range(0, 2)) - 1'b1;
                else
                    echo = $urandom;
                offer_echo(t_ms, echo, 1'b0, R_QUIET);
            end
        end

        settle();
        repeat (20) @(posedge aclk);

        $display("%0d items over a directed table and %0d register settings", items_sent,
                 NUM_PHASES);
        $display("%0d verdicts checked: %0d sampled, %0d detections", results_seen,
                 samples_seen, detects_seen);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
